// ===== rtl/life_automaton_grid_defines.svh =====
// Assertion macros used by the life grid top level.
`ifndef LIFE_AUTOMATON_GRID_DEFINES_SVH
`define LIFE_AUTOMATON_GRID_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lag_pkg.sv =====
// Types, constants and the cell rule shared by the life grid top level, controller and datapath.
package lag_pkg;

	localparam int CFG_W      = 7;
	localparam int IDX_W      = 6;
	localparam int CELL_W     = 64;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd10;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] cell_row;
		logic [IDX_W-1:0] cell_col;
	} lag_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] row_cells;
		logic [IDX_W-1:0]  row_index;
		logic              status;
		logic              last;
	} lag_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WR,
		ST_STEP_RD,
		ST_STEP_DRAIN,
		ST_STEP_FLUSH
	} lag_state_t;

	typedef struct packed {
		logic set_load;
		logic step_load;
		logic set_rd;
		logic set_commit;
		logic step_rd;
		logic flush;
	} lag_cmd_t;

	typedef struct packed {
		logic rd_last;
	} lag_sts_t;

	// B3/S23 rule for one cell, given the three columns around it in the rows above,
	// at and below it.
	function automatic logic next_cell(logic [2:0] up, logic [2:0] mid, logic [2:0] dn);
		logic [3:0] n;
		n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
			+ 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
		return (n == 4'd3) || ((n == 4'd2) && mid[1]);
	endfunction

endpackage

// ===== rtl/life_automaton_grid.sv =====
// Top level of the B3/S23 life grid: configuration registers, controller and datapath.
// A set item keeps busy high in ST_SET_RD and ST_SET_WR, which registers its single result.
// A step item keeps busy high in ST_STEP_RD, which reads one grid row per memory cycle, then
// in ST_STEP_DRAIN and ST_STEP_FLUSH; rows reach the result port in order, one row per cycle.
// Reset clears all row valid flags at once, so the grid reads as dead without a clearing pass,
// and sets row_count and col_count to 10; results cannot be stalled.
`include "life_automaton_grid_defines.svh"

module life_automaton_grid #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  lag_pkg::lag_item_t               item,
	output logic                             result_valid,
	output lag_pkg::lag_result_t             result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lag_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lag_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lag_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	logic [lag_pkg::CFG_W-1:0] row_count_q;
	logic [lag_pkg::CFG_W-1:0] col_count_q;
	logic                      cfg_wr;
	lag_pkg::lag_cmd_t         cmd;
	lag_pkg::lag_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= lag_pkg::CFG_RESET;
			col_count_q <= lag_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == lag_pkg::REG_COL_COUNT) begin
				col_count_q <= pwdata[lag_pkg::CFG_W-1:0];
			end else begin
				row_count_q <= pwdata[lag_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			lag_pkg::REG_ROW_COUNT: prdata = lag_pkg::APB_DATA_W'(row_count_q);
			lag_pkg::REG_COL_COUNT: prdata = lag_pkg::APB_DATA_W'(col_count_q);
			default:                prdata = '0;
		endcase
	end

	lag_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lag_datapath #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.row_count    (row_count_q),
		.col_count    (col_count_q),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

	`LAG_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted item did not raise busy")
	`LAG_ASSERT_NEXT(a_last_then_gap, result_valid && result.last, !result_valid, "result right after last")
	`LAG_ASSERT_NOW(a_bad_is_single, result_valid && (result.status == lag_pkg::STATUS_BAD), result.last && (result.row_cells == '0), "bad coordinate result not single")
	`LAG_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "controller issued two commands at once")

endmodule

// ===== rtl/lag_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lag_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/lag_ctrl.sv =====
// Controller state machine that sequences set and step items.
module lag_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  lag_pkg::lag_sts_t sts,
	output lag_pkg::lag_cmd_t cmd,
	output logic              busy
);

	lag_pkg::lag_state_t state_q;
	lag_pkg::lag_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lag_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lag_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (op == lag_pkg::OP_STEP) ? lag_pkg::ST_STEP_RD : lag_pkg::ST_SET_RD;
				end
			end
			lag_pkg::ST_SET_RD:     state_d = lag_pkg::ST_SET_WR;
			lag_pkg::ST_SET_WR:     state_d = lag_pkg::ST_IDLE;
			lag_pkg::ST_STEP_RD: begin
				if (sts.rd_last) begin
					state_d = lag_pkg::ST_STEP_DRAIN;
				end
			end
			lag_pkg::ST_STEP_DRAIN: state_d = lag_pkg::ST_STEP_FLUSH;
			lag_pkg::ST_STEP_FLUSH: state_d = lag_pkg::ST_IDLE;
			default:                state_d = lag_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			lag_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.set_load  = start && (op == lag_pkg::OP_SET);
				cmd.step_load = start && (op == lag_pkg::OP_STEP);
			end
			lag_pkg::ST_SET_RD:     cmd.set_rd = 1'b1;
			lag_pkg::ST_SET_WR:     cmd.set_commit = 1'b1;
			lag_pkg::ST_STEP_RD:    cmd.step_rd = 1'b1;
			lag_pkg::ST_STEP_DRAIN: cmd = '0;
			lag_pkg::ST_STEP_FLUSH: cmd.flush = 1'b1;
			default:                busy = 1'b1;
		endcase
	end

endmodule

// ===== rtl/lag_datapath.sv =====
// Datapath: grid memory, row valid flags, three-row window, rule logic and result register.
module lag_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lag_pkg::lag_cmd_t           cmd,
	input  lag_pkg::lag_item_t          item,
	input  logic [lag_pkg::CFG_W-1:0]   row_count,
	input  logic [lag_pkg::CFG_W-1:0]   col_count,
	output lag_pkg::lag_sts_t           sts,
	output lag_pkg::lag_result_t        result,
	output logic                        result_valid
);

	localparam int RIDX_W = $clog2(MAX_ROWS);

	logic [lag_pkg::CFG_W-1:0] rows_used;
	logic [lag_pkg::CFG_W-1:0] cols_used;
	logic [MAX_COLS-1:0]       col_mask;
	logic [MAX_COLS-1:0]       set_bit;

	logic [lag_pkg::IDX_W-1:0] row_q;
	logic [lag_pkg::IDX_W-1:0] col_q;
	logic                      bad_q;
	logic [RIDX_W-1:0]         rd_ctr_q;
	logic [MAX_ROWS-1:0]       valid_q;
	logic [MAX_ROWS-1:0]       valid_d;

	logic                      rd_vld_s1;
	logic [RIDX_W-1:0]         rd_idx_s1;
	logic                      valid_s1;

	logic [MAX_COLS-1:0]       above_q;
	logic [MAX_COLS-1:0]       mid_q;
	logic [RIDX_W-1:0]         mid_idx_q;
	logic                      have_mid_q;

	logic                      rd_en;
	logic [RIDX_W-1:0]         rd_addr;
	logic [MAX_COLS-1:0]       ram_rdata;
	logic [MAX_COLS-1:0]       rd_word;
	logic [MAX_COLS-1:0]       masked;
	logic [MAX_COLS-1:0]       below;
	logic [MAX_COLS+1:0]       pad_up;
	logic [MAX_COLS+1:0]       pad_mid;
	logic [MAX_COLS+1:0]       pad_dn;
	logic [MAX_COLS-1:0]       next_row;

	logic                      set_wr;
	logic                      step_wr;
	logic                      wr_en;
	logic [RIDX_W-1:0]         wr_addr;
	logic [MAX_COLS-1:0]       wr_data;
	logic                      bad_d;

	lag_pkg::lag_result_t      result_q;
	logic                      result_valid_q;

	always_comb begin
		if (row_count == '0) begin
			rows_used = lag_pkg::CFG_W'(1);
		end else if (row_count > lag_pkg::CFG_W'(MAX_ROWS)) begin
			rows_used = lag_pkg::CFG_W'(MAX_ROWS);
		end else begin
			rows_used = row_count;
		end
		if (col_count == '0) begin
			cols_used = lag_pkg::CFG_W'(1);
		end else if (col_count > lag_pkg::CFG_W'(MAX_COLS)) begin
			cols_used = lag_pkg::CFG_W'(MAX_COLS);
		end else begin
			cols_used = col_count;
		end
	end

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		assign col_mask[c] = (lag_pkg::CFG_W'(c) < cols_used);
		assign set_bit[c]  = (col_q == lag_pkg::IDX_W'(c));
		assign next_row[c] = lag_pkg::next_cell(pad_up[c+2:c], pad_mid[c+2:c],
			pad_dn[c+2:c]) & col_mask[c];
	end

	assign bad_d = (lag_pkg::CFG_W'(item.cell_row) >= rows_used)
		|| (lag_pkg::CFG_W'(item.cell_col) >= cols_used);

	assign sts.rd_last = (lag_pkg::CFG_W'(rd_ctr_q) == (rows_used - lag_pkg::CFG_W'(1)));

	assign rd_en   = cmd.set_rd || cmd.step_rd;
	assign rd_addr = cmd.set_rd ? RIDX_W'(row_q) : rd_ctr_q;

	assign rd_word = valid_s1 ? ram_rdata : '0;
	assign masked  = rd_word & col_mask;
	assign below   = cmd.flush ? '0 : masked;
	assign pad_up  = {1'b0, above_q, 1'b0};
	assign pad_mid = {1'b0, mid_q, 1'b0};
	assign pad_dn  = {1'b0, below, 1'b0};

	assign set_wr  = cmd.set_commit && !bad_q;
	assign step_wr = (rd_vld_s1 && have_mid_q) || cmd.flush;
	assign wr_en   = set_wr || step_wr;
	assign wr_addr = set_wr ? RIDX_W'(row_q) : mid_idx_q;
	assign wr_data = set_wr ? (rd_word | set_bit) : next_row;

	lag_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		valid_d = valid_q;
		if (cmd.step_load) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				valid_d[i] = valid_q[i] && (lag_pkg::CFG_W'(i) < rows_used);
			end
		end
		if (wr_en) begin
			valid_d[wr_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			rd_ctr_q       <= '0;
			rd_vld_s1      <= 1'b0;
			valid_s1       <= 1'b0;
			have_mid_q     <= 1'b0;
			bad_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_q        <= valid_d;
			rd_vld_s1      <= cmd.step_rd;
			result_valid_q <= rd_vld_s1 || cmd.set_commit;
			if (rd_en) begin
				valid_s1 <= valid_q[rd_addr];
			end
			if (cmd.set_load) begin
				bad_q <= bad_d;
			end
			if (cmd.step_load) begin
				rd_ctr_q   <= '0;
				have_mid_q <= 1'b0;
			end else if (cmd.step_rd) begin
				rd_ctr_q <= rd_ctr_q + RIDX_W'(1);
			end
			if (rd_vld_s1) begin
				have_mid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_load) begin
			row_q <= item.cell_row;
			col_q <= item.cell_col;
		end
		rd_idx_s1 <= rd_ctr_q;
		if (cmd.step_load) begin
			above_q <= '0;
			mid_q   <= '0;
		end else if (rd_vld_s1) begin
			above_q   <= mid_q;
			mid_q     <= masked;
			mid_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1) begin
			result_q.row_cells <= lag_pkg::CELL_W'(masked);
			result_q.row_index <= lag_pkg::IDX_W'(rd_idx_s1);
			result_q.status    <= lag_pkg::STATUS_OK;
			result_q.last      <= (lag_pkg::CFG_W'(rd_idx_s1)
				== (rows_used - lag_pkg::CFG_W'(1)));
		end else if (cmd.set_commit) begin
			result_q.row_cells <= '0;
			result_q.row_index <= '0;
			result_q.status    <= bad_q ? lag_pkg::STATUS_BAD : lag_pkg::STATUS_OK;
			result_q.last      <= 1'b1;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
